### rtl/bppr_pkg.sv
// ----------------------------------------------------------------------------
// bppr_pkg
// Shared constants, types and the sequencer microprogram for the ramp bank.
// ----------------------------------------------------------------------------
package bppr_pkg;

	localparam int NUM_CHANNELS = 9;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CHANNEL_W    = 4;
	localparam int MODE_W       = 2;
	localparam int POS_W        = 32;
	localparam int DT_W         = 24;
	localparam int FRAC_W       = 16;
	localparam int PROD_W       = POS_W + DT_W + 1;
	localparam int QUOT_W       = PROD_W - FRAC_W;
	localparam int SUM_W        = POS_W + 2;

	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = NUM_CHANNELS;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_MASK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANIM_EN    = 1'd1;

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK = 2'd0,
		MODE_SET  = 2'd1,
		MODE_LOAD = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		DP_NOP   = 2'd0,
		DP_MUL   = 2'd1,
		DP_SUM   = 2'd2,
		DP_CLAMP = 2'd3
	} dp_op_t;

	typedef enum logic [1:0] {
		J_NEXT     = 2'd0,
		J_HOME     = 2'd1,
		J_DISPATCH = 2'd2,
		J_LOOP     = 2'd3
	} jmp_t;

	// step addresses of the microprogram
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_IDLE = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MUL  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_SUM  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_TWB  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SWB  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_LWB  = 3'd5;

	typedef struct packed {
		logic   accept;
		dp_op_t op;
		logic   load;
		logic   emit;
		jmp_t   jmp;
	} cw_t;

	typedef struct packed {
		logic                cap;
		dp_op_t              op;
		logic                load;
		logic [CH_IDX_W-1:0] ch;
		logic                emit;
		logic                last;
	} ctrl_t;

	function automatic cw_t ucode(input logic [STEP_W-1:0] addr);
		cw_t w;
		w = '{accept: 1'b0, op: DP_NOP, load: 1'b0, emit: 1'b0, jmp: J_HOME};
		unique case (addr)
			STEP_IDLE: begin
				w.accept = 1'b1;
				w.jmp    = J_DISPATCH;
			end
			STEP_MUL: begin
				w.op  = DP_MUL;
				w.jmp = J_NEXT;
			end
			STEP_SUM: begin
				w.op  = DP_SUM;
				w.jmp = J_NEXT;
			end
			STEP_TWB: begin
				w.op   = DP_CLAMP;
				w.emit = 1'b1;
				w.jmp  = J_LOOP;
			end
			STEP_SWB: begin
				w.op   = DP_CLAMP;
				w.emit = 1'b1;
			end
			STEP_LWB: begin
				w.load = 1'b1;
				w.emit = 1'b1;
			end
			default: begin
				w.jmp = J_HOME;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/bppr_ifs.sv
// ----------------------------------------------------------------------------
// bppr_ifs
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface bppr_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [3:0]  channel;
	logic [31:0] new_position;
	logic [31:0] low_limit;
	logic [31:0] high_limit;
	logic [31:0] step_rate;
	logic [23:0] delta_time;

	modport source (
		output valid, mode, channel, new_position, low_limit, high_limit, step_rate,
		output delta_time,
		input  ready
	);
	modport sink (
		input  valid, mode, channel, new_position, low_limit, high_limit, step_rate,
		input  delta_time,
		output ready
	);
endinterface

interface bppr_res_if;
	logic        valid;
	logic        ready;
	logic [3:0]  out_channel;
	logic [31:0] position;
	logic        increasing;
	logic        last;

	modport source (
		output valid, out_channel, position, increasing, last,
		input  ready
	);
	modport sink (
		input  valid, out_channel, position, increasing, last,
		output ready
	);
endinterface

### rtl/bppr_useq.sv
// ----------------------------------------------------------------------------
// bppr_useq
// Microcode sequencer: step counter, control ROM, channel counter, jumps.
// ----------------------------------------------------------------------------
module bppr_useq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  logic [bppr_pkg::MODE_W-1:0]    cmd_mode,
	input  logic [bppr_pkg::CHANNEL_W-1:0] cmd_channel,
	input  logic                          anim_en,
	input  logic                          out_free,
	output logic                          cmd_ready,
	output bppr_pkg::ctrl_t               ctrl
);
	import bppr_pkg::*;

	logic [STEP_W-1:0]   step_q;
	logic [STEP_W-1:0]   step_nxt;
	logic [CH_IDX_W-1:0] ch_q;
	logic [CH_IDX_W-1:0] ch_nxt;
	cw_t                 cw;
	logic                go;
	logic                accepted;
	logic                ch_last;
	logic                ch_ok;

	assign cw        = ucode(step_q);
	assign go        = !cw.emit || out_free;
	assign cmd_ready = cw.accept;
	assign accepted  = cw.accept && cmd_valid;
	assign ch_last   = (ch_q == CH_IDX_W'(NUM_CHANNELS - 1));
	assign ch_ok     = (cmd_channel < CHANNEL_W'(NUM_CHANNELS));

	always_comb begin
		step_nxt = step_q;
		ch_nxt   = ch_q;
		if (go) begin
			unique case (cw.jmp)
				J_NEXT: begin
					step_nxt = step_q + STEP_W'(1);
				end
				J_HOME: begin
					step_nxt = STEP_IDLE;
				end
				J_DISPATCH: begin
					if (accepted) begin
						ch_nxt = cmd_channel[CH_IDX_W-1:0];
						if (cmd_mode == MODE_TICK) begin
							ch_nxt = '0;
							if (anim_en) step_nxt = STEP_MUL;
						end else if (cmd_mode == MODE_SET && ch_ok) begin
							step_nxt = STEP_SWB;
						end else if (cmd_mode == MODE_LOAD && ch_ok) begin
							step_nxt = STEP_LWB;
						end
					end
				end
				J_LOOP: begin
					if (ch_last) begin
						step_nxt = STEP_IDLE;
					end else begin
						step_nxt = STEP_MUL;
						ch_nxt   = ch_q + CH_IDX_W'(1);
					end
				end
				default: begin
					step_nxt = STEP_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			ch_q   <= '0;
		end else begin
			step_q <= step_nxt;
			ch_q   <= ch_nxt;
		end
	end

	always_comb begin
		ctrl.cap  = accepted;
		ctrl.op   = go ? cw.op : DP_NOP;
		ctrl.load = cw.load && go;
		ctrl.ch   = ch_q;
		ctrl.emit = cw.emit && go;
		ctrl.last = (cw.jmp != J_LOOP) || ch_last;
	end

	a_last_returns_home: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && ctrl.last |=> step_q == STEP_IDLE)
		else $error("sequencer did not return to idle after final beat");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cw.emit && !out_free |=> $stable(step_q) && $stable(ch_q))
		else $error("sequencer advanced while result register was full");

	a_loop_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && cw.jmp == J_LOOP && !ch_last |=>
		step_q == STEP_MUL && ch_q == $past(ch_q) + CH_IDX_W'(1))
		else $error("tick loop did not move to next channel");

endmodule

### rtl/bppr_dp.sv
// ----------------------------------------------------------------------------
// bppr_dp
// Datapath: channel stores, shared multiplier, saturating add and clamp.
// ----------------------------------------------------------------------------
module bppr_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bppr_pkg::ctrl_t                  ctrl,
	input  logic [bppr_pkg::NUM_CHANNELS-1:0] limit_mask,
	input  logic [bppr_pkg::POS_W-1:0]        new_position,
	input  logic [bppr_pkg::POS_W-1:0]        low_limit,
	input  logic [bppr_pkg::POS_W-1:0]        high_limit,
	input  logic [bppr_pkg::POS_W-1:0]        step_rate,
	input  logic [bppr_pkg::DT_W-1:0]         delta_time,
	output logic [bppr_pkg::POS_W-1:0]        res_position,
	output logic                             res_increasing
);
	import bppr_pkg::*;

	logic signed [POS_W-1:0]  pos_q [NUM_CHANNELS];
	logic signed [POS_W-1:0]  lo_q  [NUM_CHANNELS];
	logic signed [POS_W-1:0]  hi_q  [NUM_CHANNELS];
	logic signed [POS_W-1:0]  stp_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]  dir_q;

	logic signed [POS_W-1:0]  v_q;
	logic signed [POS_W-1:0]  lo_in_q;
	logic signed [POS_W-1:0]  hi_in_q;
	logic signed [POS_W-1:0]  stp_in_q;
	logic [DT_W-1:0]          dt_q;
	logic signed [PROD_W-1:0] prod_q;

	logic signed [POS_W-1:0]  cur_pos;
	logic                     cur_dir;
	logic signed [POS_W-1:0]  cur_lo;
	logic signed [POS_W-1:0]  cur_hi;
	logic signed [QUOT_W-1:0] quot;
	logic signed [POS_W-1:0]  quot_sat;
	logic signed [SUM_W-1:0]  sum;
	logic signed [POS_W-1:0]  sum_sat;
	logic signed [POS_W-1:0]  cl_pos;
	logic                     cl_dir;

	assign cur_pos = pos_q[ctrl.ch];
	assign cur_dir = dir_q[ctrl.ch];
	assign cur_lo  = lo_q[ctrl.ch];
	assign cur_hi  = hi_q[ctrl.ch];

	// floor(product / 2^16) then saturate
	assign quot = prod_q[PROD_W-1:FRAC_W];

	always_comb begin
		if (quot[QUOT_W-1:POS_W-1] == {(QUOT_W-POS_W+1){quot[POS_W-1]}}) begin
			quot_sat = quot[POS_W-1:0];
		end else begin
			quot_sat = quot[QUOT_W-1] ? POS_MIN : POS_MAX;
		end
		if (cur_dir) begin
			sum = SUM_W'(cur_pos) + SUM_W'(quot_sat);
		end else begin
			sum = SUM_W'(cur_pos) - SUM_W'(quot_sat);
		end
		if (sum[SUM_W-1:POS_W-1] == {(SUM_W-POS_W+1){sum[POS_W-1]}}) begin
			sum_sat = sum[POS_W-1:0];
		end else begin
			sum_sat = sum[SUM_W-1] ? POS_MIN : POS_MAX;
		end
	end

	always_comb begin
		cl_pos = v_q;
		cl_dir = cur_dir;
		if (limit_mask[ctrl.ch]) begin
			priority if (cur_lo == cur_hi) begin
				cl_pos = cur_pos;
			end else if (v_q < cur_lo) begin
				cl_pos = cur_lo;
				cl_dir = 1'b1;
			end else if (v_q > cur_hi) begin
				cl_pos = cur_hi;
				cl_dir = 1'b0;
			end else begin
				cl_pos = v_q;
			end
		end
	end

	assign res_position   = (ctrl.op == DP_CLAMP) ? cl_pos : cur_pos;
	assign res_increasing = (ctrl.op == DP_CLAMP) ? cl_dir : cur_dir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= '1;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				pos_q[i] <= '0;
				lo_q[i]  <= '0;
				hi_q[i]  <= '0;
				stp_q[i] <= '0;
			end
		end else begin
			if (ctrl.op == DP_CLAMP) begin
				pos_q[ctrl.ch] <= cl_pos;
				dir_q[ctrl.ch] <= cl_dir;
			end
			if (ctrl.load) begin
				lo_q[ctrl.ch]  <= lo_in_q;
				hi_q[ctrl.ch]  <= hi_in_q;
				stp_q[ctrl.ch] <= stp_in_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cap) begin
			v_q      <= new_position;
			lo_in_q  <= low_limit;
			hi_in_q  <= high_limit;
			stp_in_q <= step_rate;
			dt_q     <= delta_time;
		end else if (ctrl.op == DP_SUM) begin
			v_q <= sum_sat;
		end
		if (ctrl.op == DP_MUL) begin
			prod_q <= PROD_W'(stp_q[ctrl.ch]) * PROD_W'($signed({1'b0, dt_q}));
		end
	end

endmodule

### rtl/bounded_ping_pong_ramp_bank_top.sv
// ----------------------------------------------------------------------------
// bounded_ping_pong_ramp_bank_top
// Bank of ping-pong ramp channels driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : command beats (tick, set position, load limits and step).
//   res  : result beats, one per channel touched, last marks the final one.
//   cfg  : write port for limit_mask (index 0) and animation_enable (index 1).
//          Write it only while the bank is idle; the bank does not enforce it.
// Sequencing:
//   A command is taken in the idle step of the sequencer. A set or load
//   gives its single result beat from its write step. An enabled tick runs
//   three steps per channel (multiply, add, clamp/write), one channel after
//   another through the shared multiplier; the next command is taken only
//   after the beat of the last channel. Disabled ticks, unused modes and
//   out-of-range channels go back to the idle step and give no result beat.
// Reset:
//   arst_n clears positions, limits and steps to zero, all directions to up,
//   both config registers to zero and the result register to empty.
// Backpressure:
//   Results sit in one output register; while it is full and res.ready is
//   low the sequencer holds at the write step and state is not touched.
// ----------------------------------------------------------------------------
module bounded_ping_pong_ramp_bank_top (
	input  logic                            clk,
	input  logic                            arst_n,
	bppr_cmd_if.sink                        cmd,
	bppr_res_if.source                      res,
	input  logic                            cfg_wr_en,
	input  logic [bppr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bppr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import bppr_pkg::*;

	logic [NUM_CHANNELS-1:0] limit_mask_q;
	logic                    anim_en_q;
	logic                    out_valid_q;
	logic [CHANNEL_W-1:0]    out_channel_q;
	logic [POS_W-1:0]        out_position_q;
	logic                    out_inc_q;
	logic                    out_last_q;
	logic                    out_free;
	ctrl_t                   ctrl;
	logic [POS_W-1:0]        res_position;
	logic                    res_increasing;

	assign out_free = !out_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_mask_q <= '0;
			anim_en_q    <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_LIMIT_MASK: limit_mask_q <= cfg_wdata[NUM_CHANNELS-1:0];
				REG_ANIM_EN:    anim_en_q    <= cfg_wdata[0];
				default:        ;
			endcase
		end
	end

	bppr_useq u_useq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd.valid),
		.cmd_mode    (cmd.mode),
		.cmd_channel (cmd.channel),
		.anim_en     (anim_en_q),
		.out_free    (out_free),
		.cmd_ready   (cmd.ready),
		.ctrl        (ctrl)
	);

	bppr_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.limit_mask     (limit_mask_q),
		.new_position   (cmd.new_position),
		.low_limit      (cmd.low_limit),
		.high_limit     (cmd.high_limit),
		.step_rate      (cmd.step_rate),
		.delta_time     (cmd.delta_time),
		.res_position   (res_position),
		.res_increasing (res_increasing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			out_channel_q  <= CHANNEL_W'(ctrl.ch);
			out_position_q <= res_position;
			out_inc_q      <= res_increasing;
			out_last_q     <= ctrl.last;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_channel = out_channel_q;
	assign res.position    = out_position_q;
	assign res.increasing  = out_inc_q;
	assign res.last        = out_last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> out_free)
		else $error("result register overwritten while full");

	a_idle_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && !ctrl.last |=> !cmd.ready)
		else $error("command taken before final beat of a tick");

	a_last_beat_ch: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit && ctrl.op == DP_MUL |-> 1'b0)
		else $error("beat emitted during multiply step");

endmodule
